// ----- design/lfsa_pkg.sv -----
// Package for the lowest-free-slot ID allocator.
// Holds the table sizes, status and command codes, and the beat structs.
// No dependencies.
package lfsa_pkg;

  localparam int SLOTS       = 16;
  localparam int HANDLE_BITS = 32;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);

  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic                   cmd;
    logic [HANDLE_BITS-1:0] handle;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] slot;
    logic [1:0] status;
    logic [4:0] live_count;
  } out_beat_t;

endpackage

// ----- design/lfsa_cell.sv -----
// One slot of the allocator chain: handle, valid bit and scan token.
// Depends on lfsa_pkg.
module lfsa_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tok_in,
  input  lfsa_pkg::in_beat_t req,
  output logic              tok_out,
  output logic              hit
);
  import lfsa_pkg::*;

  logic                   tok_r;
  logic                   valid_r;
  logic                   valid_nxt;
  logic [HANDLE_BITS-1:0] handle_r;

  always_comb begin
    if (req.cmd == CMD_CREATE) begin
      hit = tok_r & ~valid_r;
    end else begin
      hit = tok_r & valid_r & (handle_r == req.handle);
    end
    tok_out   = tok_r & ~hit;
    valid_nxt = hit ? (req.cmd == CMD_CREATE) : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      tok_r   <= tok_in;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hit && req.cmd == CMD_CREATE) begin
      handle_r <= req.handle;
    end
  end

endmodule

// ----- design/lowest_free_slot_id_allocator_core.sv -----
// Top level of the lowest-free-slot ID allocator: request register, count,
// result register and a chain of lfsa_cell slots. Depends on lfsa_pkg.
//
//  channel  ports                      handshake
//  input    start, busy, in_data       beat taken when start & !busy
//  result   out_valid, out_data        one-cycle strobe, cannot be held off
//
// A scan token walks the cell chain one slot per cycle from slot 0.
// A hit at slot k ends the scan there; a full table or a missing handle
// lets the token run through every slot before the result is registered.
// busy drops as the result is registered, so the next beat may be taken
// in the cycle the strobe is shown. Reset empties the table at once.
module lowest_free_slot_id_allocator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lfsa_pkg::in_beat_t  in_data,
  output logic                out_valid,
  output lfsa_pkg::out_beat_t out_data
);
  import lfsa_pkg::*;

  logic              busy_r;
  logic              busy_nxt;
  in_beat_t          req_r;
  logic [SLOT_W-1:0] pos_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  out_beat_t         out_data_r;
  out_beat_t         out_data_nxt;
  logic              accept;
  logic              any_hit;
  logic              done;
  logic [SLOTS-1:0]  tok_chain;
  logic [SLOTS-1:0]  hits;

  assign accept = start & ~busy_r;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lfsa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  ((i == 0) ? accept : tok_chain[(i == 0) ? 0 : i-1]),
      .req     (req_r),
      .tok_out (tok_chain[i]),
      .hit     (hits[i])
    );
  end

  always_comb begin
    any_hit   = |hits;
    done      = busy_r & (any_hit | tok_chain[SLOTS-1]);
    count_nxt = count_r;
    out_data_nxt.slot   = 4'd0;
    out_data_nxt.status = ST_OK;
    if (any_hit) begin
      out_data_nxt.slot = 4'(pos_r);
      if (req_r.cmd == CMD_CREATE) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        count_nxt = count_r - CNT_W'(1);
      end
    end else begin
      out_data_nxt.status = (req_r.cmd == CMD_CREATE) ? ST_FULL : ST_NOT_FOUND;
    end
    out_data_nxt.live_count = 5'(count_nxt);
    busy_nxt = accept | (busy_r & ~done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= done;
      if (done) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
      pos_r <= '0;
    end else if (busy_r) begin
      pos_r <= pos_r + SLOT_W'(1);
    end
    if (done) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/lfsa_checker.sv -----
// Port-level checker for the lowest-free-slot ID allocator, with its bind.
// Depends on lfsa_pkg and lowest_free_slot_id_allocator_core.
module lfsa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input lfsa_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input lfsa_pkg::out_beat_t out_data
);
  import lfsa_pkg::*;

  a_no_double_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back result strobes");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without a beat in work");

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !$past(busy)) |-> $past(start)) else $error("busy rose without start");

  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> out_data.slot == 4'd0)
    else $error("failed beat carries a slot");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> out_data.live_count == 5'(SLOTS))
    else $error("full reported with free slots");

endmodule

bind lowest_free_slot_id_allocator_core lfsa_checker u_lfsa_checker (.*);

// ----- tb/lfsa_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for lowest_free_slot_id_allocator_core: mirrors the slot table,
// predicts every result beat and compares it with the strobed output.
// Depends on lfsa_pkg.
module lfsa_scoreboard (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  lfsa_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  lfsa_pkg::out_beat_t out_data,
  output int                  mismatches,
  output int                  outstanding
);
  import lfsa_pkg::*;

  logic [HANDLE_BITS-1:0] slot_handle [SLOTS];
  logic [SLOTS-1:0]       slot_used;
  logic [CNT_W-1:0]       used_count;
  out_beat_t              awaited_results [$];

  task automatic report(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Applies one request to the mirrored table and returns the result it gives.
  task automatic apply_slot_request(input in_beat_t req, output out_beat_t res);
    int k;
    k = -1;
    res.slot       = '0;
    res.status     = ST_OK;
    if (req.cmd == CMD_CREATE) begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!slot_used[i]) k = i;
      end
      if (k < 0) begin
        res.status = ST_FULL;
      end else begin
        slot_handle[k] = req.handle;
        slot_used[k]   = 1'b1;
        used_count++;
      end
    end else begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_handle[i] == req.handle) k = i;
      end
      if (k < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        slot_used[k] = 1'b0;
        used_count--;
      end
    end
    if (k >= 0) res.slot = 4'(k);
    res.live_count = 5'(used_count);
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      slot_used  = '0;
      used_count = '0;
      mismatches = 0;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          report("result beat with none pending", 1, 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.slot !== want.slot) report("slot", out_data.slot, want.slot);
          if (out_data.status !== want.status) report("status", out_data.status, want.status);
          if (out_data.live_count !== want.live_count) begin
            report("live_count", out_data.live_count, want.live_count);
          end
        end
      end
      if (start && !busy) begin
        apply_slot_request(in_data, want);
        awaited_results.insert(awaited_results.size(), want);
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

// ----- tb/tb_lowest_free_slot_id_allocator_core.sv -----
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, create/delete stimulus and verdict.
// Depends on lfsa_pkg, lowest_free_slot_id_allocator_core and lfsa_scoreboard.
module tb_lowest_free_slot_id_allocator_core;
  import lfsa_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_data;
  logic      out_valid;
  out_beat_t out_data;
  int        mismatches;
  int        outstanding;

  bit                     gaps_on;
  logic [HANDLE_BITS-1:0] live_handles [$];

  lowest_free_slot_id_allocator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  lfsa_scoreboard u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [HANDLE_BITS-1:0] pick_handle();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '1;
    if (roll < 45) return HANDLE_BITS'($urandom_range(5));
    return HANDLE_BITS'($urandom);
  endfunction

  // Drives one beat and returns at the edge that takes it.
  task automatic issue(input logic cmd, input logic [HANDLE_BITS-1:0] h);
    in_beat_t req;
    int       idx;
    req.cmd    = cmd;
    req.handle = h;
    idx        = -1;
    if (cmd == CMD_CREATE) begin
      if (live_handles.size() < SLOTS) live_handles.insert(live_handles.size(), h);
    end else begin
      foreach (live_handles[i]) begin
        if (idx < 0 && live_handles[i] == h) idx = i;
      end
      if (idx >= 0) live_handles.delete(idx);
    end
    if (gaps_on && $urandom_range(99) < 8) begin
      start   <= 1'b0;
      in_data <= {1'($urandom), HANDLE_BITS'($urandom)};
      do @(negedge clk); while (busy);
      do @(posedge clk); while ($urandom_range(99) < 8);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  initial begin
    int fill_bias;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    gaps_on   = 1'b1;
    fill_bias = 50;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // delete on empty table, handle extremes, duplicates, full table
    issue(CMD_DELETE, 32'd5);
    issue(CMD_CREATE, '0);
    issue(CMD_CREATE, '1);
    issue(CMD_CREATE, '0);
    for (int k = 3; k < SLOTS; k++) issue(CMD_CREATE, 32'h5A5A_0000 | k);
    issue(CMD_CREATE, 32'h0000_1234);
    issue(CMD_DELETE, '0);
    issue(CMD_DELETE, '0);
    issue(CMD_DELETE, '0);
    issue(CMD_CREATE, 32'h8000_0001);
    issue(CMD_DELETE, 32'h5A5A_0000 | (SLOTS - 1));
    issue(CMD_DELETE, '1);

    for (int n = 0; n < 1100; n++) begin
      gaps_on = !(n >= 450 && n < 750);
      if (n % 60 == 0) fill_bias = ($urandom_range(1) == 0) ? 80 : 25;
      if ($urandom_range(99) < fill_bias) begin
        issue(CMD_CREATE, pick_handle());
      end else if (live_handles.size() != 0 && $urandom_range(99) < 80) begin
        issue(CMD_DELETE, live_handles[$urandom_range(live_handles.size() - 1)]);
      end else begin
        issue(CMD_DELETE, pick_handle());
      end
    end
    start <= 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (SLOTS + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
